// ===== hdl/line_hook_pulse_dial_detector_defines.svh =====
// assertion macros shared by the detector modules
// each expects clk and rst_n in the enclosing module
`ifndef LINE_HOOK_PULSE_DIAL_DETECTOR_DEFINES_SVH
`define LINE_HOOK_PULSE_DIAL_DETECTOR_DEFINES_SVH

// same-cycle implication
`define LHPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LHPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lhpd_pkg.sv =====
package lhpd_pkg;

  localparam int TIME_BITS  = 18;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD    = 3'd0,
    CFG_MIN_SERIES_GAP = 3'd1,
    CFG_OPEN_BOUNCE    = 3'd2,
    CFG_HOOK_UP_GUARD  = 3'd3,
    CFG_MAX_PULSE      = 3'd4,
    CFG_CLOSE_BOUNCE   = 3'd5,
    CFG_HOOK_DOWN_GUARD = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_INIT  = 4'd0,
    ST_GAP   = 4'd1,
    ST_OBNC  = 4'd2,
    ST_UPG   = 4'd3,
    ST_OFF   = 4'd4,
    ST_PULSE = 4'd5,
    ST_CBNC  = 4'd6,
    ST_DNG   = 4'd7,
    ST_IDLE  = 4'd8
  } line_state_t;

  typedef enum logic [3:0] {
    EV_NONE   = 4'd0,
    EV_PAUSE  = 4'd1,
    EV_BROKEN = 4'd2,
    EV_FBREAK = 4'd3,
    EV_HOOKUP = 4'd4,
    EV_PULSE  = 4'd5,
    EV_FCLOSE = 4'd6,
    EV_CLOSED = 4'd7,
    EV_HOOKDN = 4'd8
  } ev_code_t;

  typedef struct packed {
    logic [7:0]  tick_period_ms;
    logic [15:0] min_series_gap_ms;
    logic [15:0] open_bounce_ms;
    logic [15:0] hook_up_guard_ms;
    logic [15:0] max_pulse_ms;
    logic [15:0] close_bounce_ms;
    logic [15:0] hook_down_guard_ms;
  } cfg_regs_t;

  localparam logic [7:0]  RST_TICK_PERIOD     = 8'd5;
  localparam logic [15:0] RST_MIN_SERIES_GAP  = 16'd300;
  localparam logic [15:0] RST_OPEN_BOUNCE     = 16'd20;
  localparam logic [15:0] RST_HOOK_UP_GUARD   = 16'd500;
  localparam logic [15:0] RST_MAX_PULSE       = 16'd150;
  localparam logic [15:0] RST_CLOSE_BOUNCE    = 16'd20;
  localparam logic [15:0] RST_HOOK_DOWN_GUARD = 16'd500;

  // saturating timer add
  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

endpackage

// ===== hdl/line_hook_pulse_dial_detector.sv =====
// loop-disconnect pulse dial and hook detector
//
// in channel: one word per sampling tick, in_line_broken = 1 when the loop
// is open on that tick. out channel: one word per input word, carrying the
// event code (0 none) and the line state after that tick.
// cfg port: cfg_wr_en writes cfg_wdata into register cfg_index at the clock
// edge; index 0 tick period, 1 series gap, 2 open bounce, 3 hook-up guard,
// 4 max pulse, 5 close bounce, 6 hook-down guard; index 7 is ignored.
// throughput: one word per cycle while out_ready does not stall it, set by the
// state/timer update between the input stage register and the output register.
// path: an accepted word sits in the input stage register, then the output register.
// reset (synchronous, rst_n low): line state and prior state go to initial,
// timers clear, registers take their default values, both stages empty.
// stall: while out_ready is low the output register holds its word and the
// input stage keeps one more; in_ready drops only when both are full.
`include "line_hook_pulse_dial_detector_defines.svh"

module line_hook_pulse_dial_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_line_broken,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3:0]                        out_event_code,
  output logic [3:0]                        out_current_state,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [lhpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lhpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  lhpd_pkg::cfg_regs_t   cfg;
  lhpd_pkg::ev_code_t    ev_nxt;
  lhpd_pkg::line_state_t state_nxt;

  // input stage register
  logic stg_vld_r, stg_vld_nxt;
  logic stg_brk_r;
  // output register
  logic out_vld_r, out_vld_nxt;
  logic [3:0] out_ev_r;
  logic [3:0] out_st_r;

  logic in_acc;
  logic advance;

  // the stage word moves on when the output register is empty or draining
  assign advance  = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || advance;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_acc) begin
      stg_vld_nxt = 1'b1;
    end else if (advance) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_brk_r <= in_line_broken;
    end
    if (advance) begin
      out_ev_r <= ev_nxt;
      out_st_r <= state_nxt;
    end
  end

  lhpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // state machine and timers, stepped once per word leaving the stage
  lhpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (advance),
    .brk       (stg_brk_r),
    .ev_nxt    (ev_nxt),
    .state_nxt (state_nxt)
  );

  assign out_valid         = out_vld_r;
  assign out_event_code    = out_ev_r;
  assign out_current_state = out_st_r;

  `LHPD_ASSERT_NEXT(a_stage_fills_output, stg_vld_r && !out_vld_r, out_vld_r, "stage word not moved into empty output register")
  `LHPD_ASSERT_NEXT(a_stage_word_kept, stg_vld_r && out_vld_r && !out_ready, stg_vld_r, "stage word lost during stall")
  `LHPD_ASSERT_NOW(a_ready_when_room, !stg_vld_r || !out_vld_r, in_ready, "input refused with room in the pipe")

endmodule

// ===== hdl/lhpd_cfg.sv =====
module lhpd_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lhpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lhpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output lhpd_pkg::cfg_regs_t                 cfg_o
);

  lhpd_pkg::cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (lhpd_pkg::cfg_idx_t'(cfg_index))
        lhpd_pkg::CFG_TICK_PERIOD:     cfg_nxt.tick_period_ms     = cfg_wdata[7:0];
        lhpd_pkg::CFG_MIN_SERIES_GAP:  cfg_nxt.min_series_gap_ms  = cfg_wdata;
        lhpd_pkg::CFG_OPEN_BOUNCE:     cfg_nxt.open_bounce_ms     = cfg_wdata;
        lhpd_pkg::CFG_HOOK_UP_GUARD:   cfg_nxt.hook_up_guard_ms   = cfg_wdata;
        lhpd_pkg::CFG_MAX_PULSE:       cfg_nxt.max_pulse_ms       = cfg_wdata;
        lhpd_pkg::CFG_CLOSE_BOUNCE:    cfg_nxt.close_bounce_ms    = cfg_wdata;
        lhpd_pkg::CFG_HOOK_DOWN_GUARD: cfg_nxt.hook_down_guard_ms = cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period_ms     <= lhpd_pkg::RST_TICK_PERIOD;
      cfg_r.min_series_gap_ms  <= lhpd_pkg::RST_MIN_SERIES_GAP;
      cfg_r.open_bounce_ms     <= lhpd_pkg::RST_OPEN_BOUNCE;
      cfg_r.hook_up_guard_ms   <= lhpd_pkg::RST_HOOK_UP_GUARD;
      cfg_r.max_pulse_ms       <= lhpd_pkg::RST_MAX_PULSE;
      cfg_r.close_bounce_ms    <= lhpd_pkg::RST_CLOSE_BOUNCE;
      cfg_r.hook_down_guard_ms <= lhpd_pkg::RST_HOOK_DOWN_GUARD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== hdl/lhpd_core.sv =====
`include "line_hook_pulse_dial_detector_defines.svh"

module lhpd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lhpd_pkg::cfg_regs_t       cfg,
  input  logic                      step,
  input  logic                      brk,
  output lhpd_pkg::ev_code_t        ev_nxt,
  output lhpd_pkg::line_state_t     state_nxt
);

  lhpd_pkg::line_state_t state_r, prior_r, prior_nxt;
  lhpd_pkg::time_t       brk_time_r, brk_time_nxt;
  lhpd_pkg::time_t       cls_time_r, cls_time_nxt;

  always_comb begin
    lhpd_pkg::time_t tick;
    lhpd_pkg::time_t bt_inc;
    lhpd_pkg::time_t ct_inc;
    tick   = lhpd_pkg::time_t'(cfg.tick_period_ms);
    bt_inc = lhpd_pkg::sat_add(brk_time_r, tick);
    ct_inc = lhpd_pkg::sat_add(cls_time_r, tick);

    state_nxt    = state_r;
    prior_nxt    = prior_r;
    brk_time_nxt = brk_time_r;
    cls_time_nxt = cls_time_r;
    ev_nxt       = lhpd_pkg::EV_NONE;

    case (state_r)
      lhpd_pkg::ST_GAP, lhpd_pkg::ST_UPG, lhpd_pkg::ST_OFF: begin
        if (brk) begin
          brk_time_nxt = '0;
          prior_nxt    = state_r;
          state_nxt    = lhpd_pkg::ST_OBNC;
        end else if (state_r == lhpd_pkg::ST_GAP) begin
          cls_time_nxt = ct_inc;
          if (ct_inc >= lhpd_pkg::time_t'(cfg.min_series_gap_ms)) begin
            prior_nxt = state_r;
            state_nxt = lhpd_pkg::ST_UPG;
            ev_nxt    = lhpd_pkg::EV_PAUSE;
          end
        end else if (state_r == lhpd_pkg::ST_UPG) begin
          cls_time_nxt = ct_inc;
          if (ct_inc >= lhpd_pkg::time_t'(cfg.hook_up_guard_ms)) begin
            prior_nxt = state_r;
            state_nxt = lhpd_pkg::ST_OFF;
            ev_nxt    = lhpd_pkg::EV_HOOKUP;
          end
        end
      end
      lhpd_pkg::ST_OBNC: begin
        brk_time_nxt = bt_inc;
        if (bt_inc >= lhpd_pkg::time_t'(cfg.open_bounce_ms)) begin
          prior_nxt = state_r;
          if (brk) begin
            cls_time_nxt = '0;
            state_nxt    = lhpd_pkg::ST_PULSE;
            ev_nxt       = lhpd_pkg::EV_BROKEN;
          end else begin
            // bounce: fold the break time into the close time and go back
            cls_time_nxt = lhpd_pkg::sat_add(cls_time_r, bt_inc);
            brk_time_nxt = '0;
            state_nxt    = prior_r;
            ev_nxt       = lhpd_pkg::EV_FBREAK;
          end
        end
      end
      lhpd_pkg::ST_PULSE, lhpd_pkg::ST_DNG: begin
        if (brk) begin
          brk_time_nxt = bt_inc;
          if (state_r == lhpd_pkg::ST_PULSE) begin
            if (bt_inc >= lhpd_pkg::time_t'(cfg.max_pulse_ms)) begin
              prior_nxt = state_r;
              state_nxt = lhpd_pkg::ST_DNG;
              ev_nxt    = lhpd_pkg::EV_PULSE;
            end
          end else if (bt_inc >= lhpd_pkg::time_t'(cfg.hook_down_guard_ms)) begin
            prior_nxt = state_r;
            state_nxt = lhpd_pkg::ST_IDLE;
            ev_nxt    = lhpd_pkg::EV_HOOKDN;
          end
        end else begin
          cls_time_nxt = '0;
          prior_nxt    = state_r;
          state_nxt    = lhpd_pkg::ST_CBNC;
        end
      end
      lhpd_pkg::ST_CBNC: begin
        cls_time_nxt = ct_inc;
        if (ct_inc >= lhpd_pkg::time_t'(cfg.close_bounce_ms)) begin
          prior_nxt = state_r;
          if (brk) begin
            brk_time_nxt = lhpd_pkg::sat_add(brk_time_r, ct_inc);
            cls_time_nxt = '0;
            state_nxt    = prior_r;
            ev_nxt       = lhpd_pkg::EV_FCLOSE;
          end else begin
            brk_time_nxt = '0;
            state_nxt    = lhpd_pkg::ST_GAP;
            ev_nxt       = lhpd_pkg::EV_CLOSED;
          end
        end
      end
      lhpd_pkg::ST_IDLE: begin
        if (!brk) begin
          cls_time_nxt = '0;
          prior_nxt    = state_r;
          state_nxt    = lhpd_pkg::ST_CBNC;
        end
      end
      default: begin
        // initial state and unused codes
        brk_time_nxt = '0;
        cls_time_nxt = '0;
        prior_nxt    = state_r;
        state_nxt    = lhpd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lhpd_pkg::ST_INIT;
      prior_r    <= lhpd_pkg::ST_INIT;
      brk_time_r <= '0;
      cls_time_r <= '0;
    end else if (step) begin
      state_r    <= state_nxt;
      prior_r    <= prior_nxt;
      brk_time_r <= brk_time_nxt;
      cls_time_r <= cls_time_nxt;
    end
  end

  `LHPD_ASSERT_NOW(a_event_moves_state, step && ev_nxt != lhpd_pkg::EV_NONE, state_nxt != state_r, "event reported without a state change")
  `LHPD_ASSERT_NEXT(a_init_clears, step && state_r == lhpd_pkg::ST_INIT, state_r == lhpd_pkg::ST_IDLE && brk_time_r == '0 && cls_time_r == '0, "initial step did not clear timers")
  `LHPD_ASSERT_NEXT(a_hold_when_idle, !step, $stable(state_r) && $stable(brk_time_r) && $stable(cls_time_r), "state moved without a step")

endmodule

// ===== tb/sv/tb_line_hook_pulse_dial_detector.sv =====
`timescale 1ns / 1ps

module tb_line_hook_pulse_dial_detector;
  import lhpd_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int TIMER_MAX      = (1 << TIME_BITS) - 1;
  // index 7 has no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  // opening ticks, sent msb first: init, idle, close to series gap, false break,
  // confirmed break, false close, back into the pulse break
  localparam logic [24:0] OPENING_TICKS = 25'b1100000111001111101111100;

  typedef struct packed {
    ev_code_t    ev;
    line_state_t st;
  } tick_word_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  in_line_broken = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [3:0]            out_event_code;
  logic [3:0]            out_current_state;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

  line_hook_pulse_dial_detector uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_line_broken    (in_line_broken),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_code    (out_event_code),
    .out_current_state (out_current_state),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // line samples still to be offered, and the words the line should report
  logic       loop_samples[$];
  tick_word_t hook_events_due[$];
  int         queued_total = 0;
  int         sent_total   = 0;
  int         mismatches   = 0;
  int         cycles       = 0;

  // sender / receiver pacing
  int   send_wait    = 0;
  int   rx_hold      = 0;
  logic send_burst   = 1'b0;
  logic squeeze_tog  = 1'b0;
  logic squeeze_seen = 1'b0;

  // our own copy of the detector: registers, states and both timers
  cfg_regs_t   dial_cfg;
  line_state_t line_st;
  line_state_t prior_st;
  time_t       brk_ms;
  time_t       cls_ms;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // line model
  // ---------------------------------------------------------------------------

  // timers stick at all ones instead of wrapping
  function automatic time_t timer_add(input time_t a, input time_t b);
    int unsigned total;
    total = 32'(a);
    total += 32'(b);
    if (total > TIMER_MAX) return '1;
    return total[TIME_BITS-1:0];
  endfunction

  // every change of state remembers where it came from
  function automatic void move_to(input line_state_t next_st);
    prior_st = line_st;
    line_st  = next_st;
  endfunction

  function automatic tick_word_t advance_line(input logic brk);
    tick_word_t w;
    time_t      tick;
    tick = time_t'(dial_cfg.tick_period_ms);
    w.ev = EV_NONE;
    case (line_st)
      ST_GAP, ST_UPG, ST_OFF: begin
        if (brk) begin
          brk_ms = '0;
          move_to(ST_OBNC);
        end else if (line_st == ST_GAP) begin
          cls_ms = timer_add(cls_ms, tick);
          if (cls_ms >= time_t'(dial_cfg.min_series_gap_ms)) begin
            move_to(ST_UPG);
            w.ev = EV_PAUSE;
          end
        end else if (line_st == ST_UPG) begin
          cls_ms = timer_add(cls_ms, tick);
          if (cls_ms >= time_t'(dial_cfg.hook_up_guard_ms)) begin
            move_to(ST_OFF);
            w.ev = EV_HOOKUP;
          end
        end
      end
      ST_OBNC: begin
        brk_ms = timer_add(brk_ms, tick);
        if (brk_ms >= time_t'(dial_cfg.open_bounce_ms)) begin
          if (brk) begin
            cls_ms = '0;
            move_to(ST_PULSE);
            w.ev = EV_BROKEN;
          end else begin
            // bounce: the break time counts as closed time, back where we were
            cls_ms = timer_add(cls_ms, brk_ms);
            brk_ms = '0;
            move_to(prior_st);
            w.ev = EV_FBREAK;
          end
        end
      end
      ST_PULSE, ST_DNG: begin
        if (brk) begin
          brk_ms = timer_add(brk_ms, tick);
          if (line_st == ST_PULSE) begin
            if (brk_ms >= time_t'(dial_cfg.max_pulse_ms)) begin
              move_to(ST_DNG);
              w.ev = EV_PULSE;
            end
          end else if (brk_ms >= time_t'(dial_cfg.hook_down_guard_ms)) begin
            move_to(ST_IDLE);
            w.ev = EV_HOOKDN;
          end
        end else begin
          cls_ms = '0;
          move_to(ST_CBNC);
        end
      end
      ST_CBNC: begin
        cls_ms = timer_add(cls_ms, tick);
        if (cls_ms >= time_t'(dial_cfg.close_bounce_ms)) begin
          if (brk) begin
            brk_ms = timer_add(brk_ms, cls_ms);
            cls_ms = '0;
            move_to(prior_st);
            w.ev = EV_FCLOSE;
          end else begin
            brk_ms = '0;
            move_to(ST_GAP);
            w.ev = EV_CLOSED;
          end
        end
      end
      ST_IDLE: begin
        if (!brk) begin
          cls_ms = '0;
          move_to(ST_CBNC);
        end
      end
      default: begin
        // initial state: input ignored, timers cleared
        brk_ms = '0;
        cls_ms = '0;
        move_to(ST_IDLE);
      end
    endcase
    w.st = line_st;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // pacing
  // ---------------------------------------------------------------------------

  // at least half the words go back to back, the rest may wait a short or a long while
  function automatic int draw_gap();
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 13);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued line samples, predicts on every accepted word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        hook_events_due.push_back(advance_line(in_line_broken));
        sent_total++;
      end
      // only move on once the word on the bus has gone
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (loop_samples.size() > 0) begin
          in_valid       <= 1'b1;
          in_line_broken <= loop_samples.pop_front();
          send_wait = send_burst ? 0 : draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each word with the oldest prediction, paces out_ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tick_word_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (hook_events_due.size() == 0) begin
          $display("%0t: word with nothing predicted, event_code %0d current_state %0d",
                   $time, out_event_code, out_current_state);
          mismatches++;
        end else begin
          due = hook_events_due.pop_front();
          if (out_event_code !== due.ev) begin
            $display("%0t: event_code expected %0d, actual %0d",
                     $time, due.ev, out_event_code);
            mismatches++;
          end
          if (out_current_state !== due.st) begin
            $display("%0t: current_state expected %0d, actual %0d",
                     $time, due.st, out_current_state);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (squeeze_tog != squeeze_seen) begin
        // long hold-off so both stages fill and in_ready drops
        squeeze_seen = squeeze_tog;
        rx_hold = SQUEEZE_CYCLES;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        rx_hold = draw_gap();
        out_ready <= (rx_hold == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("line_hook_pulse_dial_detector verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_sample(input logic brk);
    loop_samples.push_back(brk);
    queued_total++;
  endfunction

  // idle: every sample sent and every word back, then some slack
  task automatic wait_idle();
    while (sent_total != queued_total || hook_events_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TICK_PERIOD:     dial_cfg.tick_period_ms     = val[7:0];
      CFG_MIN_SERIES_GAP:  dial_cfg.min_series_gap_ms  = val;
      CFG_OPEN_BOUNCE:     dial_cfg.open_bounce_ms     = val;
      CFG_HOOK_UP_GUARD:   dial_cfg.hook_up_guard_ms   = val;
      CFG_MAX_PULSE:       dial_cfg.max_pulse_ms       = val;
      CFG_CLOSE_BOUNCE:    dial_cfg.close_bounce_ms    = val;
      CFG_HOOK_DOWN_GUARD: dial_cfg.hook_down_guard_ms = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // all seven registers; the upper byte of the tick period write is junk
  task automatic load_profile(input cfg_regs_t p);
    write_reg(CFG_TICK_PERIOD, {8'($urandom), p.tick_period_ms});
    write_reg(CFG_MIN_SERIES_GAP, p.min_series_gap_ms);
    write_reg(CFG_OPEN_BOUNCE, p.open_bounce_ms);
    write_reg(CFG_HOOK_UP_GUARD, p.hook_up_guard_ms);
    write_reg(CFG_MAX_PULSE, p.max_pulse_ms);
    write_reg(CFG_CLOSE_BOUNCE, p.close_bounce_ms);
    write_reg(CFG_HOOK_DOWN_GUARD, p.hook_down_guard_ms);
    end_writes();
  endtask

  // a threshold under seven ticks long, not always a whole number of ticks
  function automatic logic [15:0] near_ticks(input int unsigned tick);
    int unsigned v;
    v = tick * $urandom_range(0, 6) + $urandom_range(0, tick - 1);
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic cfg_regs_t random_profile();
    cfg_regs_t   p;
    int unsigned tick;
    tick = $urandom_range(1, 255);
    p.tick_period_ms     = tick[7:0];
    p.min_series_gap_ms  = near_ticks(tick);
    p.open_bounce_ms     = near_ticks(tick);
    p.hook_up_guard_ms   = near_ticks(tick);
    p.max_pulse_ms       = near_ticks(tick);
    p.close_bounce_ms    = near_ticks(tick);
    p.hook_down_guard_ms = near_ticks(tick);
    return p;
  endfunction

  // run length in ticks for a span of ms, up to two ticks over, kept within 1 to 400
  function automatic int span_for(input int unsigned ms);
    int n;
    if (dial_cfg.tick_period_ms == 0) return $urandom_range(1, 4);
    n = int'(ms / 32'(dial_cfg.tick_period_ms) + $urandom_range(0, 2));
    if (n < 1) n = 1;
    if (n > 400) n = 400;
    return n;
  endfunction

  // alternating open/closed runs sized from the current thresholds, some noise
  task automatic queue_line_runs(input int n_items);
    int          made;
    int          len;
    logic        lvl;
    int unsigned ob, mp, dn, cb, gp, up;
    made = 0;
    lvl  = 1'($urandom_range(0, 1));
    ob = 32'(dial_cfg.open_bounce_ms);
    mp = 32'(dial_cfg.max_pulse_ms);
    dn = 32'(dial_cfg.hook_down_guard_ms);
    cb = 32'(dial_cfg.close_bounce_ms);
    gp = 32'(dial_cfg.min_series_gap_ms);
    up = 32'(dial_cfg.hook_up_guard_ms);
    while (made < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) queue_sample(1'($urandom_range(0, 1)));
      end else begin
        if (lvl) begin
          case ($urandom_range(0, 3))
            0:       len = $urandom_range(1, 2);     // bounce
            1:       len = span_for(ob);             // just around the debounce
            2:       len = span_for(ob + $urandom_range(0, mp)); // dial pulse
            default: len = span_for(ob + mp + dn);   // hang up
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0:       len = $urandom_range(1, 2);
            1:       len = span_for(cb);             // inter-pulse make
            2:       len = span_for(cb + gp);        // end of a series
            default: len = span_for(cb + gp + up);   // off-hook
          endcase
        end
        repeat (len) queue_sample(lvl);
        lvl = !lvl;
      end
      made += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_regs_t p;
    int        k;

    dial_cfg = '{RST_TICK_PERIOD, RST_MIN_SERIES_GAP, RST_OPEN_BOUNCE, RST_HOOK_UP_GUARD,
                 RST_MAX_PULSE, RST_CLOSE_BOUNCE, RST_HOOK_DOWN_GUARD};
    line_st  = ST_INIT;
    prior_st = ST_INIT;
    brk_ms   = '0;
    cls_ms   = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // hand-picked opening under the reset thresholds
    for (k = 24; k >= 0; k--) queue_sample(OPENING_TICKS[k]);
    wait_idle();

    // more of the reset thresholds
    queue_line_runs(150);
    wait_idle();

    // four compact random profiles; the first also pokes the dead index
    for (k = 0; k < 4; k++) begin
      if (k == 0) write_reg(CFG_UNUSED_IDX, 16'hFFFF);
      load_profile(random_profile());
      queue_line_runs(70);
      wait_idle();
    end

    // every threshold zero: each check passes at once
    p = '0;
    p.tick_period_ms = 8'($urandom_range(1, 255));
    load_profile(p);
    queue_line_runs(80);
    wait_idle();

    // zero tick period: timers stand still
    p = '0;
    p.min_series_gap_ms  = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 300));
    p.open_bounce_ms     = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 300));
    p.hook_up_guard_ms   = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 300));
    p.max_pulse_ms       = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 300));
    p.close_bounce_ms    = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 300));
    p.hook_down_guard_ms = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 300));
    load_profile(p);
    queue_line_runs(60);
    wait_idle();

    // largest tick, largest thresholds
    p = '1;
    load_profile(p);
    queue_line_runs(150);
    wait_idle();

    // sender flat out while the receiver sits on out_ready for a long stretch
    load_profile(random_profile());
    queue_line_runs(120);
    @(posedge clk);
    send_burst  <= 1'b1;
    squeeze_tog <= !squeeze_tog;
    wait_idle();
    send_burst <= 1'b0;

    if (mismatches == 0 && hook_events_due.size() == 0) begin
      $display("line_hook_pulse_dial_detector verification clean");
    end else begin
      $display("line_hook_pulse_dial_detector verification failed");
    end
    $finish;
  end

endmodule
